@@ hdl/wsrm_pkg.sv @@
// Package: constants, codes and cell link types for the wildcard/star matcher.
package wsrm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned CntW       = $clog2(MaxPattern + 1);

  localparam logic [7:0] StarCh = 8'd42;
  localparam logic [7:0] DotCh  = 8'd46;

  typedef enum logic [1:0] {
    FuncPattern = 2'd0,
    FuncText    = 2'd1,
    FuncFinish  = 2'd2,
    FuncIgnore  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusTooLong  = 2'd1,
    StatusLeadStar = 2'd2,
    StatusSpare    = 2'd3
  } status_e;

  // What one cell shows its right-hand neighbor.
  typedef struct packed {
    logic       valid;     // cell holds a pattern byte
    logic [7:0] pat;       // pattern byte
    logic       row;       // match row bit of this cell
    logic       row_left;  // match row bit of the cell to the left
    logic       wave;      // text update is at this cell this cycle
    logic [7:0] text;      // text byte traveling with the update
  } link_t;

  // Broadcast controls from the top level.
  typedef struct packed {
    logic       app;       // append pattern byte
    logic       clr;       // clear for next query
    logic [7:0] ch;
  } ctl_t;

endpackage

@@ hdl/wsrm_if.sv @@
// Channel interfaces: input word (func, ch) and result word (matched, status).
interface wsrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

interface wsrm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] status;

  modport source (output valid, output matched, output status, input ready);
  modport sink (input valid, input matched, input status, output ready);
endinterface

@@ hdl/wsrm_cell.sv @@
// One pattern cell: holds a pattern byte and its match row bit.
module wsrm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           first_i,
  input  wsrm_pkg::ctl_t  ctl_i,
  input  wsrm_pkg::link_t left_i,
  output wsrm_pkg::link_t right_o
);

  logic       valid_q, valid_d;
  logic [7:0] pat_q, pat_d;
  logic       row_q, row_d;
  logic       wave_q;
  logic [7:0] text_q;
  logic       old_q;  // left cell's row bit before this update

  logic is_star, lit_hit, prev_hit, text_row, load;

  always_comb begin
    is_star  = (pat_q == wsrm_pkg::StarCh);
    lit_hit  = (pat_q == text_q) || (pat_q == wsrm_pkg::DotCh);
    prev_hit = (left_i.pat == text_q) || (left_i.pat == wsrm_pkg::DotCh);

    // literal test before the star test; a leading star never matches
    if (is_star && first_i) begin
      text_row = 1'b0;
    end else if (lit_hit) begin
      text_row = old_q;
    end else if (is_star) begin
      text_row = left_i.row_left | (prev_hit & row_q);
    end else begin
      text_row = 1'b0;
    end

    load    = ctl_i.app && left_i.valid && !valid_q;
    valid_d = valid_q;
    pat_d   = pat_q;
    row_d   = row_q;
    if (ctl_i.clr) begin
      valid_d = 1'b0;
      row_d   = 1'b0;
    end else if (load) begin
      valid_d = 1'b1;
      pat_d   = ctl_i.ch;
      if (ctl_i.ch == wsrm_pkg::StarCh && !first_i) begin
        row_d = left_i.row_left;
      end else begin
        row_d = 1'b0;
      end
    end else if (wave_q && valid_q) begin
      row_d = text_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row_q   <= 1'b0;
      wave_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      row_q   <= row_d;
      wave_q  <= left_i.wave && !ctl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    text_q <= left_i.text;
    old_q  <= left_i.row;
  end

  assign right_o = '{valid:    valid_q,
                     pat:      pat_q,
                     row:      row_q,
                     row_left: left_i.row,
                     wave:     wave_q,
                     text:     text_q};

endmodule

@@ hdl/wildcard_star_regex_matcher.sv @@
// Top level: pattern/text matcher built as a chain of MaxPattern cells.
// A finish result is registered and valid in the cycle after the finish word is taken.
// A text word sends an update wave down the cell chain, one cell per cycle, and the
// block takes no new word until the wave has left the last cell.
// Reset (async, active low) empties the pattern, sets row bit 0 and clears status.
// No clearing pass: a finish word clears the block in the same cycle it is taken.
module wildcard_star_regex_matcher (
  input  logic           clk_i,
  input  logic           rst_ni,
  wsrm_in_if.sink        in_i,
  wsrm_out_if.source     out_o
);

  localparam int unsigned N = wsrm_pkg::MaxPattern;

  logic [wsrm_pkg::CntW-1:0] count_q, count_d;
  logic [1:0]                status_q, status_d;
  logic                      row0_q, row0_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_matched_q;
  logic [1:0]                out_status_q;

  wsrm_pkg::link_t links [N:0];
  wsrm_pkg::ctl_t  ctl;
  logic [N:0]      row_vec;
  logic [N-1:0]    wave_vec;
  logic            busy, accept, take_text, take_finish, take_pat;

  // Busy while an update wave is anywhere in the chain.
  assign busy     = |wave_vec;
  assign in_i.ready = !busy && (!out_valid_q || out_o.ready);
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    take_pat    = 1'b0;
    take_text   = 1'b0;
    take_finish = 1'b0;
    unique case (wsrm_pkg::func_e'(in_i.func))
      wsrm_pkg::FuncPattern: take_pat    = accept;
      wsrm_pkg::FuncText:    take_text   = accept;
      wsrm_pkg::FuncFinish:  take_finish = accept;
      wsrm_pkg::FuncIgnore:  ;
      default: ;
    endcase
  end

  // Head of the chain: row bit 0 stands in as cell 0, always valid.
  assign links[0] = '{valid:    1'b1,
                      pat:      8'h00,
                      row:      row0_q,
                      row_left: 1'b0,
                      wave:     take_text,
                      text:     in_i.ch};

  assign ctl = '{app: take_pat, clr: take_finish, ch: in_i.ch};

  for (genvar g = 0; g < N; g++) begin : g_cell
    wsrm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .first_i (g == 0),
      .ctl_i   (ctl),
      .left_i  (links[g]),
      .right_o (links[g+1])
    );
    assign wave_vec[g]  = links[g+1].wave;
    assign row_vec[g+1] = links[g+1].row;
  end
  assign row_vec[0] = row0_q;

  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    row0_d      = row0_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (take_finish) begin
      count_d     = '0;
      status_d    = wsrm_pkg::StatusOk;
      row0_d      = 1'b1;
      out_valid_d = 1'b1;
    end else if (take_text) begin
      row0_d = 1'b0;  // nonempty text never matches an empty pattern prefix
    end else if (take_pat) begin
      if (count_q == wsrm_pkg::CntW'(N)) begin
        // capacity reached: byte dropped, first error wins
        if (status_q == wsrm_pkg::StatusOk) status_d = wsrm_pkg::StatusTooLong;
      end else begin
        count_d = count_q + 1'b1;
        if (count_q == '0 && in_i.ch == wsrm_pkg::StarCh &&
            status_q == wsrm_pkg::StatusOk) begin
          status_d = wsrm_pkg::StatusLeadStar;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= wsrm_pkg::StatusOk;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      status_q    <= status_d;
      row0_q      <= row0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (take_finish) begin
      out_matched_q <= row_vec[count_q];
      out_status_q  <= status_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_matched_q;
  assign out_o.status  = out_status_q;

endmodule

@@ hdl/wsrm_checker.sv @@
// Port-level checker for the matcher, bound to the top level.
module wsrm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_func_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic [1:0] out_status_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_func_i == wsrm_pkg::FuncText) |=> !in_ready_i)
    else $error("ready high right after a text word");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_func_i == wsrm_pkg::FuncFinish) |=> out_valid_i)
    else $error("finish word gave no result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc && in_func_i == wsrm_pkg::FuncFinish))
    else $error("result without finish word");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i != wsrm_pkg::StatusSpare))
    else $error("unused status code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_matched_i) && $stable(out_status_i)))
    else $error("stalled result word changed");

endmodule

bind wildcard_star_regex_matcher wsrm_checker u_wsrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched),
  .out_status_i  (out_o.status)
);
